@@ hw/rtl/tscf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and functions of the telemetry sentence CRC framer.
// No dependencies; used by tscf_front, tscf_fifo, tscf_back and the top level.
package tscf_pkg;

	// Default depth of the queue between front and back
	localparam int FIFO_DEPTH = 4;

	// CRC-16 with polynomial 0x1021, seed 0xFFFF, MSB first, no final XOR
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Framing characters
	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	// One queued transaction: the body byte, its last flag and the CRC
	// as it stands after this byte
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] crc;
	} entry_t;

	// One byte through the CRC, bit by bit
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Upper-case ASCII hex digit of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = CHAR_ZERO + {4'h0, n};
		end else begin
			r = CHAR_UPPER_A + {4'h0, n} - 8'd10;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tscf_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one sentence byte per transaction, valid/ready handshake.
// No dependencies.
interface tscf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tscf_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Output channel: one transmit byte per transaction with framing flags.
// No dependencies.
interface tscf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       sentence_end;

	modport source (output valid, output out_byte, output run_end, output sentence_end,
		input ready);
	modport sink (input valid, input out_byte, input run_end, input sentence_end,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tscf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts sentence bytes, tracks the dollar prefix and the running CRC,
// and pushes each byte with its CRC into the queue. Depends on tscf_pkg, tscf_in_if.
module tscf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	tscf_in_if.sink             in_ch,
	input  wire logic           q_full,
	output logic                push,
	output tscf_pkg::entry_t    push_entry
);

	logic [15:0] crc_q;
	logic        prefix_q;
	logic        skip;
	logic [15:0] crc_next;

	// Leading dollars stay out of the CRC
	always_comb begin
		in_ch.ready = !q_full;
		push        = in_ch.valid && in_ch.ready;
		skip        = prefix_q && (in_ch.data_byte == tscf_pkg::CHAR_DOLLAR);
		crc_next    = skip ? crc_q : tscf_pkg::crc_feed(crc_q, in_ch.data_byte);
		push_entry.data_byte = in_ch.data_byte;
		push_entry.last_byte = in_ch.last_byte;
		push_entry.crc       = crc_next;
	end

	// Running state; the last byte returns it to the sentence start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= tscf_pkg::CRC_INIT;
			prefix_q <= 1'b1;
		end else if (push) begin
			if (in_ch.last_byte) begin
				crc_q    <= tscf_pkg::CRC_INIT;
				prefix_q <= 1'b1;
			end else begin
				crc_q    <= crc_next;
				prefix_q <= skip;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tscf_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Short queue of byte entries between front and back end.
// Depends on tscf_pkg.
module tscf_fifo #(
	parameter int DEPTH = tscf_pkg::FIFO_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  tscf_pkg::entry_t    push_entry,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output tscf_pkg::entry_t    head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tscf_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_comb begin
		full       = (count_q == CW'(DEPTH));
		head_valid = (count_q != '0);
		head       = mem_q[rd_ptr_q];
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count not advanced");

endmodule
`default_nettype wire

@@ hw/rtl/tscf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Back end: drains queue entries, sends the body byte and, after the last byte,
// the '*', four hex digits and newline. Depends on tscf_pkg, tscf_out_if.
module tscf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  tscf_pkg::entry_t    head,
	output logic                pop,
	tscf_out_if.source          out_ch
);

	localparam logic [2:0] STEP_BODY = 3'd0;
	localparam logic [2:0] STEP_STAR = 3'd1;
	localparam logic [2:0] STEP_HEX3 = 3'd2;
	localparam logic [2:0] STEP_HEX2 = 3'd3;
	localparam logic [2:0] STEP_HEX1 = 3'd4;
	localparam logic [2:0] STEP_HEX0 = 3'd5;
	localparam logic [2:0] STEP_NL   = 3'd6;

	logic [2:0] step_q;
	logic [2:0] step_next;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       sentence_end_q;
	logic       out_free;
	logic       load;
	logic [7:0] nx_byte;
	logic       nx_run_end;
	logic       nx_sentence_end;

	// Next output byte by sequencer step
	always_comb begin
		out_free        = !out_valid_q || out_ch.ready;
		load            = head_valid && out_free;
		nx_byte         = head.data_byte;
		nx_run_end      = 1'b0;
		nx_sentence_end = 1'b0;
		step_next       = step_q;
		case (step_q)
			STEP_BODY: begin
				nx_byte    = head.data_byte;
				nx_run_end = !head.last_byte;
				step_next  = head.last_byte ? STEP_STAR : STEP_BODY;
			end
			STEP_STAR: begin
				nx_byte   = tscf_pkg::CHAR_STAR;
				step_next = STEP_HEX3;
			end
			STEP_HEX3: begin
				nx_byte   = tscf_pkg::hex_char(head.crc[15:12]);
				step_next = STEP_HEX2;
			end
			STEP_HEX2: begin
				nx_byte   = tscf_pkg::hex_char(head.crc[11:8]);
				step_next = STEP_HEX1;
			end
			STEP_HEX1: begin
				nx_byte   = tscf_pkg::hex_char(head.crc[7:4]);
				step_next = STEP_HEX0;
			end
			STEP_HEX0: begin
				nx_byte   = tscf_pkg::hex_char(head.crc[3:0]);
				step_next = STEP_NL;
			end
			STEP_NL: begin
				nx_byte         = tscf_pkg::CHAR_NEWLINE;
				nx_run_end      = 1'b1;
				nx_sentence_end = 1'b1;
				step_next       = STEP_BODY;
			end
			default: begin
				step_next = STEP_BODY;
			end
		endcase
		// Entry leaves the queue with its final output byte
		pop = load && ((step_q == STEP_BODY && !head.last_byte) || step_q == STEP_NL);
	end

	// Sequencer step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_BODY;
		end else if (load) begin
			step_q <= step_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= nx_byte;
			run_end_q      <= nx_run_end;
			sentence_end_q <= nx_sentence_end;
		end
	end

	always_comb begin
		out_ch.valid        = out_valid_q;
		out_ch.out_byte     = out_byte_q;
		out_ch.run_end      = run_end_q;
		out_ch.sentence_end = sentence_end_q;
	end

	a_trailer_holds_entry: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != STEP_BODY |-> head_valid) else $error("trailer without queued entry");
	a_newline_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sentence_end_q |-> run_end_q
			&& out_byte_q == tscf_pkg::CHAR_NEWLINE) else $error("bad sentence end");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_NL) else $error("step out of range");

endmodule
`default_nettype wire

@@ hw/rtl/telemetry_sentence_crc_framer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the telemetry sentence CRC framer: front end, queue, back end.
// Depends on tscf_pkg, tscf_in_if, tscf_out_if, tscf_front, tscf_fifo, tscf_back.
//
//   channel  | dir | payload                              | handshake
//   ---------+-----+--------------------------------------+------------
//   in_ch    | in  | data_byte[7:0], last_byte            | valid/ready
//   out_ch   | out | out_byte[7:0], run_end, sentence_end | valid/ready
//
// Body bytes pass at one per cycle while out_ch.ready stays high and no trailer is
// being sent; the CRC update sits in the front end cycle. A last byte holds the back
// end sequencer through the trailer ('*', four hex digits, newline). Meanwhile the
// FIFO_DEPTH-entry queue takes bytes, and in_ch.ready drops only while it is full.
// out_ch.valid rises once an accepted byte has passed the queue and the output register.
// arst_n sets the CRC to 0xFFFF, re-arms the dollar prefix and empties the queue.
module telemetry_sentence_crc_framer_core #(
	parameter int FIFO_DEPTH = tscf_pkg::FIFO_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tscf_in_if.sink    in_ch,
	tscf_out_if.source out_ch
);

	logic             q_full;
	logic             push;
	logic             pop;
	logic             head_valid;
	tscf_pkg::entry_t push_entry;
	tscf_pkg::entry_t head;

	tscf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	tscf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	tscf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire
